/* sv/equal_count_subarray_counter_unit_defines.svh */
// ----------------------------------------------------------------------------
// equal count subarray counter: assertion macros
// shared checks, written against clk and rst of the including module
// ----------------------------------------------------------------------------
`ifndef EQUAL_COUNT_SUBARRAY_COUNTER_UNIT_DEFINES_SVH
`define EQUAL_COUNT_SUBARRAY_COUNTER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define ECSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ECSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ecsc_pkg.sv */
// ----------------------------------------------------------------------------
// ecsc_pkg
// shared sizes, codes and types of the equal count subarray counter
// ----------------------------------------------------------------------------
package ecsc_pkg;

  // sequence limits
  localparam int MAX_LEN    = 8192;
  localparam int HIST_DEPTH = 2 * MAX_LEN + 1;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(MAX_LEN + 2);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);

  // field widths
  localparam int ELEM_W  = 32;
  localparam int TOTAL_W = 26;

  // histogram entry: epoch tag over count
  localparam int EPOCH_W = 8;
  localparam int ENTRY_W = EPOCH_W + CNT_W;

  localparam logic [SLOT_W-1:0]  SLOT_CENTER = SLOT_W'(MAX_LEN);
  localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(HIST_DEPTH - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_FIRST  = 2'd0,
    REG_VALUE_SECOND = 2'd1
  } reg_idx_t;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // front end control
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } front_state_t;

  // item handed from the front end to the histogram update
  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot;
    logic [EPOCH_W-1:0] epoch;
    logic               over;
    logic               last;
  } hist_op_t;

  // clear pass write request
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
  } clr_req_t;

  // one result item
  typedef struct packed {
    logic [TOTAL_W-1:0] subarray_count;
    logic               too_long;
    logic               final_count;
  } result_t;

endpackage

/* sv/ecsc_channels.sv */
// ----------------------------------------------------------------------------
// ecsc channels
// valid/ready channels for input and result items
// ----------------------------------------------------------------------------
interface ecsc_in_if;
  import ecsc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;
  logic                     last_element;

  modport source (output valid, output element, output last_element, input ready);
  modport sink (input valid, input element, input last_element, output ready);
endinterface

interface ecsc_out_if;
  import ecsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] subarray_count;
  logic               too_long;
  logic               final_count;

  modport source (
    output valid, output subarray_count, output too_long, output final_count, input ready
  );
  modport sink (
    input valid, input subarray_count, input too_long, input final_count, output ready
  );
endinterface

/* sv/equal_count_subarray_counter_unit.sv */
// items are registered into the update stage, which pushes each result into the queue
// 1 item per cycle while the queue has room, one histogram read-modify-write each
// reset: a clear pass over 16385 histogram entries, one per cycle, holds off input
// each 255th sequence end adds a drain state and the same clear pass
// configuration writes are taken at any time, the registers reset to zero
// ----------------------------------------------------------------------------
// equal_count_subarray_counter_unit
// counts subarrays with equal counts of two configured values, per sequence
// ----------------------------------------------------------------------------
`include "equal_count_subarray_counter_unit_defines.svh"

module equal_count_subarray_counter_unit (
  input  logic                            clk,
  input  logic                            rst,
  ecsc_in_if.sink                         in_item,
  ecsc_out_if.source                      out_item,
  input  logic                            cfg_we,
  input  logic [ecsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ecsc_pkg::*;

  hist_op_t              s1_op;
  clr_req_t              clr;
  logic                  front_clearing;
  logic [SLOT_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  upd_we;
  logic [SLOT_W-1:0]     upd_addr;
  logic [ENTRY_W-1:0]    upd_data;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  res_valid;
  result_t               res;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic                  room;

  // every accepted item has a queue slot waiting for it
  assign room = (q_count + OUTQ_CNT_W'(s1_op.valid)) < OUTQ_CNT_W'(OUTQ_DEPTH);

  ecsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .room      (room),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_addr   (rd_addr),
    .op        (s1_op),
    .clr       (clr),
    .clearing  (front_clearing)
  );

  // write port shared by the clear pass and the update stage
  assign ram_we    = clr.we || upd_we;
  assign ram_waddr = clr.we ? clr.addr : upd_addr;
  assign ram_wdata = clr.we ? '0 : upd_data;

  ecsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ecsc_update u_update (
    .clk       (clk),
    .rst       (rst),
    .op        (s1_op),
    .rd_data   (rd_data),
    .wr_en     (upd_we),
    .wr_addr   (upd_addr),
    .wr_data   (upd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ecsc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_item  (out_item),
    .count     (q_count)
  );

  // checks
  `ECSC_ASSERT_SAME(a_no_item_in_clear, front_clearing, !(in_item.valid && in_item.ready), "item accepted during clear pass")
  `ECSC_ASSERT_SAME(a_write_port_free, front_clearing, !upd_we, "histogram update collides with clear pass")
  `ECSC_ASSERT_NEXT(a_item_reaches_update, in_item.valid && in_item.ready, s1_op.valid, "accepted item missing in update stage")
  `ECSC_ASSERT_SAME(a_queue_bound, s1_op.valid, q_count < OUTQ_CNT_W'(OUTQ_DEPTH), "result queue has no room for item")

endmodule

/* sv/ecsc_ram.sv */
// ----------------------------------------------------------------------------
// ecsc_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ecsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/ecsc_front.sv */
// ----------------------------------------------------------------------------
// ecsc_front
// input stage: registers, balance, length, epoch and histogram clear pass
// ----------------------------------------------------------------------------
module ecsc_front (
  input  logic                         clk,
  input  logic                         rst,
  ecsc_in_if.sink                      in_item,
  input  logic                         room,
  input  logic                         cfg_we,
  input  logic [ecsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [ecsc_pkg::SLOT_W-1:0]  rd_addr,
  output ecsc_pkg::hist_op_t           op,
  output ecsc_pkg::clr_req_t           clr,
  output logic                         clearing
);
  import ecsc_pkg::*;

  front_state_t               state;
  logic signed [ELEM_W-1:0]   value_first;
  logic signed [ELEM_W-1:0]   value_second;
  logic [SLOT_W-1:0]          bal_slot;
  logic [SLOT_W-1:0]          slot_next;
  logic [LEN_W-1:0]           elem_count;
  logic [EPOCH_W-1:0]         epoch;
  logic [EPOCH_W-1:0]         epoch_next;
  logic [SLOT_W-1:0]          clr_addr;
  logic                       accept;
  logic                       hit_first;
  logic                       hit_second;
  logic                       len_full;

  assign in_item.ready = (state == ST_RUN) && room;
  assign accept        = in_item.valid && in_item.ready;
  assign hit_first     = (in_item.element == value_first);
  assign hit_second    = (in_item.element == value_second);
  assign len_full      = (elem_count >= LEN_W'(MAX_LEN));
  assign epoch_next    = (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_W'(1);

  // balance step, held as an offset slot around the center entry
  always_comb begin
    slot_next = bal_slot;
    unique case ({hit_first, hit_second})
      2'b10:   slot_next = bal_slot + SLOT_W'(1);
      2'b01:   slot_next = bal_slot - SLOT_W'(1);
      default: slot_next = bal_slot;
    endcase
  end

  assign rd_addr  = slot_next;
  assign clearing = (state == ST_CLEAR);
  assign clr.we   = clearing;
  assign clr.addr = clr_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      value_first  <= '0;
      value_second <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VALUE_FIRST:  value_first  <= cfg_data;
        REG_VALUE_SECOND: value_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bal_slot   <= SLOT_CENTER;
      elem_count <= '0;
      epoch      <= EPOCH_FIRST;
    end else if (accept) begin
      if (in_item.last_element) begin
        bal_slot   <= SLOT_CENTER;
        elem_count <= '0;
        epoch      <= epoch_next;
      end else if (!len_full) begin
        bal_slot   <= slot_next;
        elem_count <= elem_count + LEN_W'(1);
      end
    end
  end

  // hand-off register to the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      op.valid <= 1'b0;
    end else begin
      op.valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    op.slot  <= slot_next;
    op.epoch <= epoch;
    op.over  <= len_full;
    op.last  <= in_item.last_element;
  end

  // clear pass after reset and whenever the epoch tag wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == SLOT_LAST) begin
            clr_addr <= '0;
            state    <= ST_RUN;
          end else begin
            clr_addr <= clr_addr + SLOT_W'(1);
          end
        end
        ST_RUN: begin
          if (accept && in_item.last_element && (epoch == EPOCH_LAST)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_CLEAR;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

/* sv/ecsc_update.sv */
// ----------------------------------------------------------------------------
// ecsc_update
// histogram read-modify-write with forwarding, running total, result build
// ----------------------------------------------------------------------------
module ecsc_update (
  input  logic                         clk,
  input  logic                         rst,
  input  ecsc_pkg::hist_op_t           op,
  input  logic [ecsc_pkg::ENTRY_W-1:0] rd_data,
  output logic                         wr_en,
  output logic [ecsc_pkg::SLOT_W-1:0]  wr_addr,
  output logic [ecsc_pkg::ENTRY_W-1:0] wr_data,
  output logic                         res_valid,
  output ecsc_pkg::result_t            res
);
  import ecsc_pkg::*;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_sum;
  logic               fwd_valid;
  logic [SLOT_W-1:0]  fwd_slot;
  logic [EPOCH_W-1:0] fwd_epoch;
  logic [CNT_W-1:0]   fwd_count;
  logic [EPOCH_W-1:0] stored_tag;
  logic [CNT_W-1:0]   stored_cnt;
  logic [CNT_W-1:0]   reset_cnt;
  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   new_cnt;

  assign stored_tag = rd_data[ENTRY_W-1:CNT_W];
  assign stored_cnt = rd_data[CNT_W-1:0];
  assign reset_cnt  = (op.slot == SLOT_CENTER) ? CNT_W'(1) : '0;

  // current count: last write wins, then a tag match, else the cleared value
  always_comb begin
    priority if (fwd_valid && (fwd_slot == op.slot) && (fwd_epoch == op.epoch)) begin
      cur_cnt = fwd_count;
    end else if (stored_tag == op.epoch) begin
      cur_cnt = stored_cnt;
    end else begin
      cur_cnt = reset_cnt;
    end
  end

  assign new_cnt   = cur_cnt + CNT_W'(1);
  assign total_sum = total + TOTAL_W'(cur_cnt);

  assign wr_en   = op.valid && !op.over;
  assign wr_addr = op.slot;
  assign wr_data = {op.epoch, new_cnt};

  // result item
  assign res_valid          = op.valid;
  assign res.subarray_count = op.over ? total : total_sum;
  assign res.too_long       = op.over;
  assign res.final_count    = op.last;

  // running total, cleared after the last item of a sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (op.valid) begin
      if (op.last) begin
        total <= '0;
      end else if (!op.over) begin
        total <= total_sum;
      end
    end
  end

  // forwarding register covers the read issued in the cycle of this write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_slot  <= op.slot;
    fwd_epoch <= op.epoch;
    fwd_count <= new_cnt;
  end

endmodule

/* sv/ecsc_outq.sv */
// ----------------------------------------------------------------------------
// ecsc_outq
// small result queue between the update stage and the output channel
// ----------------------------------------------------------------------------
module ecsc_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  ecsc_pkg::result_t               push_data,
  ecsc_out_if.source                      out_item,
  output logic [ecsc_pkg::OUTQ_CNT_W-1:0] count
);
  import ecsc_pkg::*;

  result_t               slots [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic                  pop;
  result_t               head;

  assign head                    = slots[rd_ptr];
  assign out_item.valid          = (count != '0);
  assign out_item.subarray_count = head.subarray_count;
  assign out_item.too_long       = head.too_long;
  assign out_item.final_count    = head.final_count;
  assign pop                     = out_item.valid && out_item.ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + OUTQ_CNT_W'(1);
        2'b01:   count <= count - OUTQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* tb/equal_count_subarray_counter_unit_tb.sv */
// ----------------------------------------------------------------------------
// equal_count_subarray_counter_unit_tb
// drives element sequences through the counter under random valid/ready gaps
// and checks every result item against a behavioral count of balanced
// subarrays, kept per sequence alongside the configured values
// ----------------------------------------------------------------------------
module equal_count_subarray_counter_unit_tb;
  import ecsc_pkg::*;

  // unassigned register indexes, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  // cycles with no item moving on either side before the run is called hung;
  // covers the clear pass over all 16385 histogram entries plus receiver stalls
  localparam int STALL_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [ELEM_W-1:0] element;
    logic              last_element;
  } seq_item_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ecsc_in_if  in_ch ();
  ecsc_out_if out_ch ();

  equal_count_subarray_counter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // configured values as the block should hold them
  logic [ELEM_W-1:0] cfg_first;
  logic [ELEM_W-1:0] cfg_second;

  // per-sequence state of the behavioral counter
  int              seq_balance;
  int unsigned     balance_hits[int];
  longint unsigned seq_total;
  int unsigned     seq_length;

  seq_item_t pending_elements[$];
  result_t   expected_counts[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // append at the tail of the pending and expected queues
  function automatic void add_pending(seq_item_t it);
    pending_elements.insert(pending_elements.size(), it);
  endfunction

  function automatic void add_expected(result_t r);
    expected_counts.insert(expected_counts.size(), r);
  endfunction

  function automatic void restart_sequence();
    seq_balance = 0;
    balance_hits.delete();
    balance_hits[0] = 1;
    seq_total = 0;
    seq_length = 0;
  endfunction

  // one element into the running count, returns the result item it causes
  function automatic result_t count_balanced_subarrays(logic [ELEM_W-1:0] elem,
                                                        logic last);
    result_t res;
    logic    over;
    over = (seq_length >= MAX_LEN);
    if (!over) begin
      if (elem == cfg_first) seq_balance++;
      if (elem == cfg_second) seq_balance--;
      if (!balance_hits.exists(seq_balance)) balance_hits[seq_balance] = 0;
      seq_total += balance_hits[seq_balance];
      balance_hits[seq_balance]++;
      seq_length++;
    end
    res.subarray_count = seq_total[TOTAL_W-1:0];
    res.too_long       = over;
    res.final_count    = last;
    if (last) restart_sequence();
    return res;
  endfunction

  // mostly hits on the two values, some near misses and some full-range noise
  function automatic logic [ELEM_W-1:0] pick_element();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return cfg_first;
    if (sel < 70) return cfg_second;
    if (sel < 85) return cfg_first ^ (32'd1 << $urandom_range(ELEM_W - 1));
    return $urandom;
  endfunction

  // random-length sequences, the final one always closed with a last item
  task automatic queue_random_sequences(input int n_items);
    int left;
    int len;
    seq_item_t it;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        it.element      = pick_element();
        it.last_element = (i == len - 1);
        add_pending(it);
      end
      left -= len;
    end
  endtask

  task automatic queue_item(input logic [ELEM_W-1:0] elem, input logic last);
    seq_item_t it;
    it.element      = elem;
    it.last_element = last;
    add_pending(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VALUE_FIRST) cfg_first = data;
    else if (idx == REG_VALUE_SECOND) cfg_second = data;
  endtask

  // sender holds off until every queued item has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_elements.size() != 0 || in_ch.valid || expected_counts.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver: present the next pending item when the slot frees up
  always @(posedge clk) begin : drive_items
    seq_item_t next_item;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        add_expected(count_balanced_subarrays(in_ch.element, in_ch.last_element));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_elements.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.element      <= next_item.element;
          in_ch.last_element <= next_item.last_element;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin : check_counts
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result item, count=%0d too_long=%0b final=%0b",
                   $time, out_ch.subarray_count, out_ch.too_long, out_ch.final_count);
          mismatch_count++;
        end else begin
          want = expected_counts.pop_front();
          if (out_ch.subarray_count !== want.subarray_count) begin
            $display("%0t: subarray_count expected %0d actual %0d",
                     $time, want.subarray_count, out_ch.subarray_count);
            mismatch_count++;
          end
          if (out_ch.too_long !== want.too_long) begin
            $display("%0t: too_long expected %0b actual %0b",
                     $time, want.too_long, out_ch.too_long);
            mismatch_count++;
          end
          if (out_ch.final_count !== want.final_count) begin
            $display("%0t: final_count expected %0b actual %0b",
                     $time, want.final_count, out_ch.final_count);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_VALUE_FIRST;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.element      = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_first          = '0;
    cfg_second         = '0;
    send_idle_pct      = 38;
    recv_idle_pct      = 82;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    restart_sequence();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extremes of the element range as the two values, unused indexes ignored
    write_reg(REG_VALUE_FIRST, 32'h8000_0000);
    write_reg(REG_VALUE_SECOND, 32'h7FFF_FFFF);
    write_reg(REG_UNUSED_LO, 32'h8000_0000);
    write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h0000_0000, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b0);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b1);
    // single-element sequence
    queue_item(32'h7FFF_FFFF, 1'b1);
    // elements equal to neither value
    queue_item(32'h5555_5555, 1'b0);
    queue_item(32'hAAAA_AAAA, 1'b1);
    wait_drained();

    // both values equal: every matching element keeps the balance
    write_reg(REG_VALUE_FIRST, 32'hFFFF_FFFF);
    write_reg(REG_VALUE_SECOND, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_item(32'hFFFF_FFFF, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b0);
    queue_item(32'h0000_0000, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // sender idles often, receiver stalls most of the time
    send_idle_pct = 38;
    recv_idle_pct = 82;
    write_reg(REG_VALUE_FIRST, $urandom_range(15));
    write_reg(REG_VALUE_SECOND, $urandom_range(15));
    @(negedge clk);
    queue_random_sequences(600);
    wait_drained();

    // the other way round, full-range values
    send_idle_pct = 82;
    recv_idle_pct = 38;
    write_reg(REG_VALUE_FIRST, $urandom);
    write_reg(REG_VALUE_SECOND, $urandom);
    @(negedge clk);
    queue_random_sequences(600);
    wait_drained();

    // no idling from here on; reset values first, then random ones
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_VALUE_FIRST, 32'd0);
    write_reg(REG_VALUE_SECOND, 32'd0);
    @(negedge clk);
    queue_random_sequences(300);
    wait_drained();
    write_reg(REG_VALUE_FIRST, $urandom);
    write_reg(REG_VALUE_SECOND, $urandom);
    @(negedge clk);
    queue_random_sequences(300);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ecsc_pkg.sv
sv/ecsc_channels.sv
sv/ecsc_ram.sv
sv/ecsc_front.sv
sv/ecsc_update.sv
sv/ecsc_outq.sv
sv/equal_count_subarray_counter_unit.sv
tb/equal_count_subarray_counter_unit_tb.sv
